/* sv/nlv_pkg.sv */
// Shared types, character codes and helpers for the numeric literal validator.
package nlv_pkg;

  localparam int unsigned ChW = 8;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChDot   = 8'h2E;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpE   = 8'h45;
  localparam logic [ChW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ChW-1:0] ChLowA  = 8'h61;
  localparam logic [ChW-1:0] ChLowE  = 8'h65;
  localparam logic [ChW-1:0] ChLowF  = 8'h66;
  localparam logic [ChW-1:0] ChLowI  = 8'h69;
  localparam logic [ChW-1:0] ChLowN  = 8'h6E;
  localparam logic [ChW-1:0] CaseGap = 8'h20;

  localparam int unsigned     KwLen = 3;
  localparam logic [1:0]      KwLenCode = 2'd3;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_AFT_SIGN = 3'd1,
    PH_AFT_EXP  = 3'd2,
    PH_BODY     = 3'd3,
    PH_FAIL     = 3'd4
  } phase_e;

  typedef struct packed {
    logic by_keyword;
    logic is_numeric;
  } result_t;

  function automatic logic is_sign(input logic [ChW-1:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic is_exp(input logic [ChW-1:0] c);
    return (c == ChLowE) || (c == ChUpE);
  endfunction

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Letter expected at a given position of "inf".
  function automatic logic [ChW-1:0] inf_letter(input logic [1:0] idx);
    logic [ChW-1:0] r;
    case (idx)
      2'd0:    r = ChLowI;
      2'd1:    r = ChLowN;
      default: r = ChLowF;
    endcase
    return r;
  endfunction

  // Letter expected at a given position of "nan".
  function automatic logic [ChW-1:0] nan_letter(input logic [1:0] idx);
    logic [ChW-1:0] r;
    case (idx)
      2'd0:    r = ChLowN;
      2'd1:    r = ChLowA;
      default: r = ChLowN;
    endcase
    return r;
  endfunction

endpackage

/* sv/numeric_literal_validator.sv */
// Top level of the numeric literal validator: input register, parser and result register.
//
// Usage:
//   The slave stream takes one character byte per word on s_axis_tdata; a 0 byte
//   ends the string. Nothing is returned for ordinary bytes. For each 0 byte one
//   word appears on the master stream: bit 0 is_numeric, bit 1 by_keyword.
//   A string is numeric when it is inf or nan (any case, optional sign) or
//   when it passes the decimal recognizer (sign, digits, one dot, one exponent
//   with a non-empty, optionally signed tail).
// Timing:
//   A byte is first registered in the input register, then folds into the parse
//   state; the verdict for a 0 byte is loaded into the result register once that
//   register has room, and from there it is offered on the master stream.
//   One byte per cycle is taken as long as results drain.
// Reset:
//   Clears both valid flags and returns the parser to the start of a string.
// Stall:
//   While the result register is full and m_axis_tready is low, a 0 byte waits
//   in the input register and s_axis_tready drops; ordinary bytes keep flowing.
module numeric_literal_validator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [nlv_pkg::ChW-1:0] s_axis_tdata,   // [7:0] ch
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata    // [0] is_numeric, [1] by_keyword, [7:2] zero
);

  logic                    in_valid_q, in_valid_d;
  logic [nlv_pkg::ChW-1:0] ch_q;
  logic                    out_free;
  logic                    go;
  logic                    is_term;
  nlv_pkg::result_t        verdict;
  nlv_pkg::result_t        out_res;

  assign is_term       = (ch_q == nlv_pkg::ChNul);
  // a terminator needs room in the result register; other bytes just advance
  assign go            = in_valid_q && (!is_term || out_free);
  assign s_axis_tready = !in_valid_q || go;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (go) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ch_q <= s_axis_tdata;
    end
  end

  nlv_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .ch_i     (ch_q),
    .result_o (verdict)
  );

  nlv_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (go && is_term),
    .result_i (verdict),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.by_keyword, out_res.is_numeric};

`ifndef SYNTHESIS
  a_term_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && is_term && !out_free |=> in_valid_q && (ch_q == nlv_pkg::ChNul))
    else $error("blocked terminator lost from input register");
  a_byte_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !is_term |-> s_axis_tready)
    else $error("ordinary byte stalled the input");
  a_out_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0))
    else $error("result padding not zero");
`endif

endmodule

/* sv/nlv_parser.sv */
// Per-string parse state: recognizer phase, keyword matcher and end-of-string verdict.
module nlv_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,      // consume ch_i this cycle
  input  logic [nlv_pkg::ChW-1:0]  ch_i,
  output nlv_pkg::result_t         result_o   // verdict if ch_i is the terminator
);

  nlv_pkg::phase_e phase_q, phase_d;
  logic            dot_q, dot_d;
  logic            exp_q, exp_d;
  logic [1:0]      letters_q, letters_d;
  logic            signed_q, signed_d;
  logic            inf_q, inf_d;
  logic            nan_q, nan_d;

  logic                    is_nul;
  logic [nlv_pkg::ChW-1:0] low;
  nlv_pkg::phase_e         body_ph;
  logic                    body_dot;
  logic                    body_exp;

  assign is_nul = (ch_i == nlv_pkg::ChNul);

  assign result_o.by_keyword = (letters_q == nlv_pkg::KwLenCode) && (inf_q || nan_q);
  assign result_o.is_numeric = result_o.by_keyword || (phase_q == nlv_pkg::PH_BODY);

  // Digit, dot or exponent mark inside the number body.
  always_comb begin
    body_ph  = nlv_pkg::PH_FAIL;
    body_dot = 1'b0;
    body_exp = 1'b0;
    if (nlv_pkg::is_digit(ch_i)) begin
      body_ph = nlv_pkg::PH_BODY;
    end else if ((ch_i == nlv_pkg::ChDot) && !dot_q) begin
      body_ph  = nlv_pkg::PH_BODY;
      body_dot = 1'b1;
    end else if (nlv_pkg::is_exp(ch_i) && !exp_q) begin
      body_ph  = nlv_pkg::PH_AFT_EXP;
      body_exp = 1'b1;
    end
  end

  // Fold upper case to lower case for the keyword compare.
  always_comb begin
    low = ch_i;
    if ((ch_i >= nlv_pkg::ChUpA) && (ch_i <= nlv_pkg::ChUpZ)) begin
      low = ch_i + nlv_pkg::CaseGap;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    dot_d     = dot_q;
    exp_d     = exp_q;
    letters_d = letters_q;
    signed_d  = signed_q;
    inf_d     = inf_q;
    nan_d     = nan_q;
    if (go_i && is_nul) begin
      phase_d   = nlv_pkg::PH_START;
      dot_d     = 1'b0;
      exp_d     = 1'b0;
      letters_d = 2'd0;
      signed_d  = 1'b0;
      inf_d     = 1'b1;
      nan_d     = 1'b1;
    end else if (go_i) begin
      // keyword matcher
      if (inf_q || nan_q) begin
        if ((letters_q == 2'd0) && !signed_q && nlv_pkg::is_sign(ch_i)) begin
          signed_d = 1'b1;
        end else if (letters_q == nlv_pkg::KwLenCode) begin
          inf_d = 1'b0;
          nan_d = 1'b0;
        end else begin
          if (low != nlv_pkg::inf_letter(letters_q)) inf_d = 1'b0;
          if (low != nlv_pkg::nan_letter(letters_q)) nan_d = 1'b0;
          letters_d = letters_q + 2'd1;
        end
      end
      // recognizer
      case (phase_q)
        nlv_pkg::PH_START: begin
          if (nlv_pkg::is_exp(ch_i)) begin
            phase_d = nlv_pkg::PH_FAIL;
          end else if (nlv_pkg::is_sign(ch_i)) begin
            phase_d = nlv_pkg::PH_AFT_SIGN;
          end else begin
            phase_d = body_ph;
            dot_d   = dot_q | body_dot;
            exp_d   = exp_q | body_exp;
          end
        end
        nlv_pkg::PH_AFT_EXP: begin
          if (nlv_pkg::is_sign(ch_i)) begin
            phase_d = nlv_pkg::PH_AFT_SIGN;
          end else begin
            phase_d = body_ph;
            dot_d   = dot_q | body_dot;
            exp_d   = exp_q | body_exp;
          end
        end
        nlv_pkg::PH_AFT_SIGN, nlv_pkg::PH_BODY: begin
          phase_d = body_ph;
          dot_d   = dot_q | body_dot;
          exp_d   = exp_q | body_exp;
        end
        default: begin
          phase_d = nlv_pkg::PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= nlv_pkg::PH_START;
      dot_q     <= 1'b0;
      exp_q     <= 1'b0;
      letters_q <= 2'd0;
      signed_q  <= 1'b0;
      inf_q     <= 1'b1;
      nan_q     <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      dot_q     <= dot_d;
      exp_q     <= exp_d;
      letters_q <= letters_d;
      signed_q  <= signed_d;
      inf_q     <= inf_d;
      nan_q     <= nan_d;
    end
  end

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && is_nul) |=> (phase_q == nlv_pkg::PH_START) && !dot_q && !exp_q
                         && (letters_q == 2'd0) && inf_q && nan_q)
    else $error("parse state not cleared after terminator");
  a_dot_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q |-> (phase_q != nlv_pkg::PH_START))
    else $error("dot recorded while at start of string");
  a_exp_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q |-> (phase_q != nlv_pkg::PH_START))
    else $error("exponent recorded while at start of string");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_i |=> $stable(phase_q) && $stable(letters_q) && $stable(inf_q) && $stable(nan_q))
    else $error("parse state moved without a consumed word");
`endif

endmodule

/* sv/nlv_out_stage.sv */
// Result register holding one verdict until the receiver takes it.
module nlv_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nlv_pkg::result_t result_i,
  output logic             free_o,    // a verdict can be loaded this cycle
  output logic             valid_o,
  input  logic             ready_i,
  output nlv_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  nlv_pkg::result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign result_o = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("verdict loaded over one not yet taken");
  a_keyword_implies_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.by_keyword |-> data_q.is_numeric)
    else $error("keyword match without numeric flag");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded verdict not presented");
`endif

endmodule
